FILE: rtl/pn9fie_pkg.sv
// ----------------------------------------------------------------------------
// pn9fie_pkg
// Types, constants and coding functions shared by the PN9 whitening and
// convolutional interleave encoder.
// ----------------------------------------------------------------------------
package pn9fie_pkg;

  // PN9 seed loaded at every frame start.
  localparam logic [8:0] PN9_SEED = 9'h1FF;

  // Trellis terminator byte, sent unwhitened.
  localparam logic [7:0] TERM_BYTE = 8'h0B;

  // Byte counts reported with each result.
  localparam logic [2:0] BC_WHITEN = 3'd1;
  localparam logic [2:0] BC_FEC    = 3'd4;

  // Result buffer depth and pointer widths.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Configuration register indexes (byte address bits above the word offset).
  localparam logic REG_FEC_MODE = 1'b0;

  // Convolutional encoder output table, indexed by a 4-bit window.
  localparam logic [1:0] CODER_LUT [16] = '{
    2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
    2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
  };

  // One result item.
  typedef struct packed {
    logic [31:0] coded_word;
    logic [2:0]  byte_count;
    logic        frame_end;
  } res_t;

  // Up to two results written into the buffer at once.
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

  // Per-frame encoder state.
  typedef struct packed {
    logic [8:0]  pn9;
    logic [2:0]  mem;
    logic [15:0] held;
    logic        half_full;
  } enc_state_t;

  // Advance the PN9 register by two nibble steps.
  function automatic logic [8:0] pn9_advance(input logic [8:0] r);
    logic [8:0] s;
    s = {r[3:0] ^ r[8:5], r[8:4]};
    return {s[3:0] ^ s[8:5], s[8:4]};
  endfunction

  // Code one byte through the constraint-4 encoder; upper byte goes first.
  function automatic logic [15:0] code_byte(input logic [2:0] mem, input logic [7:0] b);
    logic [10:0] sr;
    logic [15:0] acc;
    sr = {mem, b};
    acc = '0;
    for (int n = 0; n < 8; n++) begin
      acc[(7 - n) * 2 +: 2] = CODER_LUT[sr[(10 - n) -: 4]];
    end
    return acc;
  endfunction

  // Interleave the four coded bytes of a group into one word.
  function automatic logic [31:0] interleave(input logic [15:0] first,
                                             input logic [15:0] second);
    logic [7:0]  g [4];
    logic [31:0] w;
    g[0] = first[15:8];
    g[1] = first[7:0];
    g[2] = second[15:8];
    g[3] = second[7:0];
    w = '0;
    for (int j = 0; j < 16; j++) begin
      w[(15 - j) * 2 +: 2] = g[3 - (j % 4)][(j / 4) * 2 +: 2];
    end
    return w;
  endfunction

endpackage

FILE: rtl/pn9fie_in_if.sv
// ----------------------------------------------------------------------------
// pn9fie_in_if
// Request channel carrying one frame byte and its end-of-frame flag.
// ----------------------------------------------------------------------------
interface pn9fie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_frame;

  modport source (output valid, output data_byte, output last_of_frame, input ready);
  modport sink   (input valid, input data_byte, input last_of_frame, output ready);
endinterface

FILE: rtl/pn9fie_out_if.sv
// ----------------------------------------------------------------------------
// pn9fie_out_if
// Result channel carrying a coded or whitened word.
// ----------------------------------------------------------------------------
interface pn9fie_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] coded_word;
  logic [2:0]  byte_count;
  logic        frame_end;

  modport source (output valid, output coded_word, output byte_count, output frame_end,
                  input ready);
  modport sink   (input valid, input coded_word, input byte_count, input frame_end,
                  output ready);
endinterface

FILE: rtl/pn9fie_coder.sv
// ----------------------------------------------------------------------------
// pn9fie_coder
// Whitens one byte; in FEC mode runs the convolutional encoder and interleaver
// and adds the trellis terminators at frame end. Gives the next encoder state.
// ----------------------------------------------------------------------------
module pn9fie_coder import pn9fie_pkg::*; (
  input  logic       [7:0] data_byte_i,
  input  logic             last_of_frame_i,
  input  logic             fec_mode_i,
  input  enc_state_t       state_i,
  output enc_state_t       state_o,
  output push_t            push_o
);

  logic [7:0]  white;
  logic [15:0] pair_data;
  logic [15:0] pair_term1;
  logic [15:0] pair_term2;
  logic [31:0] word_data;
  logic [31:0] word_end;
  res_t        res_data;
  res_t        res_end;

  // Whitening and encoder lanes; the terminators are coded in parallel.
  assign white      = data_byte_i ^ state_i.pn9[7:0];
  assign pair_data  = code_byte(state_i.mem, white);
  assign pair_term1 = code_byte(white[2:0], TERM_BYTE);
  assign pair_term2 = code_byte(TERM_BYTE[2:0], TERM_BYTE);
  assign word_data  = interleave(state_i.held, pair_data);

  // With a held half both terminators pair; else the data byte takes the first.
  assign word_end = state_i.half_full ? interleave(pair_term1, pair_term2)
                                      : interleave(pair_data, pair_term1);

  assign res_data = '{coded_word: word_data, byte_count: BC_FEC, frame_end: 1'b0};
  assign res_end  = '{coded_word: word_end, byte_count: BC_FEC, frame_end: 1'b1};

  // Result selection and next state.
  always_comb begin
    state_o       = state_i;
    state_o.pn9   = pn9_advance(state_i.pn9);
    push_o.num    = 2'd0;
    push_o.first  = res_data;
    push_o.second = res_end;
    if (!fec_mode_i) begin
      push_o.num   = 2'd1;
      push_o.first = '{coded_word: {24'd0, white}, byte_count: BC_WHITEN,
                       frame_end: last_of_frame_i};
    end else begin
      state_o.mem = white[2:0];
      if (state_i.half_full) begin
        state_o.half_full = 1'b0;
        push_o.num        = last_of_frame_i ? 2'd2 : 2'd1;
      end else begin
        state_o.held      = pair_data;
        state_o.half_full = 1'b1;
        if (last_of_frame_i) begin
          push_o.num   = 2'd1;
          push_o.first = res_end;
        end
      end
    end
    // Every frame end restarts the scrambler and the encoder.
    if (last_of_frame_i) begin
      state_o.pn9       = PN9_SEED;
      state_o.mem       = 3'd0;
      state_o.half_full = 1'b0;
    end
  end

endmodule

FILE: rtl/pn9fie_res_fifo.sv
// ----------------------------------------------------------------------------
// pn9fie_res_fifo
// Small result buffer that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module pn9fie_res_fifo import pn9fie_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  space_o,
  output logic  valid_o,
  output res_t  head_o
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RES_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_PTR_W-1:0] wr_ptr_nx;
  logic                 pop;

  // Room for two results keeps the input side free of the output ready.
  assign space_o = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i & valid_o;

  assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + RES_PTR_W'(push_i.num);
    rd_ptr_d = rd_ptr_q + RES_PTR_W'(pop);
    cnt_d    = cnt_q + RES_CNT_W'(push_i.num) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.second;
    end
  end

endmodule

FILE: rtl/pn9_fec_interleave_encoder.sv
// ----------------------------------------------------------------------------
// pn9_fec_interleave_encoder
// PN9 whitener with optional rate-1/2 convolutional coding and interleaving.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one frame byte per request, with last_of_frame on the final
//   byte. res_o returns results: in whitening mode one whitened byte per
//   request; in FEC mode one interleaved 32-bit word per two coded bytes, and
//   at frame end the terminator group, so a request gives zero, one or two
//   results. fec_mode is to be written through the APB port only while the
//   block is idle; the block does not enforce this. A request is taken in
//   every cycle while the result buffer has room for two entries; with an
//   empty buffer its first result is on res_o the cycle after acceptance and
//   a second once the first is taken. The per-byte work is one pass of
//   whitening, eight parallel trellis lookups and a wiring permutation
//   between the state registers and a four-entry result buffer. Sustained
//   rate is one byte per cycle while results are drained at least as fast as
//   they are produced. Reset empties the buffer, loads the PN9 seed and
//   selects whitening mode. When the receiver stalls, results collect in the
//   buffer and req_i.ready drops once fewer than two entries are free.
// ----------------------------------------------------------------------------
module pn9_fec_interleave_encoder import pn9fie_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  pn9fie_in_if.sink           req_i,
  pn9fie_out_if.source        res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic       fec_mode_q, fec_mode_d;
  enc_state_t state_q, state_d, state_nx;
  push_t      push_nx;
  push_t      push;
  logic       accept;
  logic       space;
  logic       cfg_wr;
  res_t       head;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == REG_FEC_MODE) ? {31'd0, fec_mode_q} : 32'd0;

  always_comb begin
    fec_mode_d = fec_mode_q;
    if (cfg_wr && paddr[2] == REG_FEC_MODE) begin
      fec_mode_d = pwdata[0];
    end
  end

  // Request handshake.
  assign req_i.ready = space;
  assign accept      = req_i.valid & space;

  pn9fie_coder u_coder (
    .data_byte_i     (req_i.data_byte),
    .last_of_frame_i (req_i.last_of_frame),
    .fec_mode_i      (fec_mode_q),
    .state_i         (state_q),
    .state_o         (state_nx),
    .push_o          (push_nx)
  );

  // Results are written only for an accepted request.
  always_comb begin
    push     = push_nx;
    state_d  = state_q;
    if (accept) begin
      state_d = state_nx;
    end else begin
      push.num = 2'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fec_mode_q         <= 1'b0;
      state_q.pn9        <= PN9_SEED;
      state_q.mem        <= 3'd0;
      state_q.held       <= 16'd0;
      state_q.half_full  <= 1'b0;
    end else begin
      fec_mode_q         <= fec_mode_d;
      state_q.pn9        <= state_d.pn9;
      state_q.mem        <= state_d.mem;
      state_q.held       <= state_d.held;
      state_q.half_full  <= state_d.half_full;
    end
  end

  pn9fie_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (res_o.ready),
    .space_o (space),
    .valid_o (res_o.valid),
    .head_o  (head)
  );

  assign res_o.coded_word = head.coded_word;
  assign res_o.byte_count = head.byte_count;
  assign res_o.frame_end  = head.frame_end;

endmodule

FILE: rtl/pn9fie_checker.sv
// ----------------------------------------------------------------------------
// pn9fie_checker
// Port-level checks of the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pn9fie_checker import pn9fie_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_byte_count_i
);

  // A pending result is not withdrawn before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // Every result reports one whitened byte or a full coded group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_byte_count_i == BC_WHITEN || out_byte_count_i == BC_FEC))
    else $error("illegal byte count on result");

  // Back-pressure on requests only comes from results waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("request refused with no result pending");

  // An accepted request always leaves a result or room for one more request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> in_ready_i)
    else $error("buffer filled from an empty state in one request");

endmodule

bind pn9_fec_interleave_encoder pn9fie_checker u_pn9fie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_byte_count_i (res_o.byte_count)
);

FILE: tb/pn9_fec_interleave_encoder_tb.sv
// ----------------------------------------------------------------------------
// pn9_fec_interleave_encoder_tb
// Self-checking bench for the PN9 whitener and convolutional interleave
// encoder. A driver feeds frame bytes with random gaps and a sink drains
// results with random stalls. A monitor predicts every coded result when a
// request is accepted and compares it field by field with the block's output.
// The coding mode is changed over APB between phases, also in mid-frame.
// ----------------------------------------------------------------------------
module pn9_fec_interleave_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Coding modes held in the fec_mode register.
  typedef enum logic {
    MODE_WHITEN = 1'b0,
    MODE_FEC    = 1'b1
  } coding_mode_e;

  // Register map: the mode register is register 0.
  localparam int unsigned FEC_MODE_REG  = 0;
  localparam logic [2:0]  FEC_MODE_ADDR = 3'(4 * FEC_MODE_REG);

  // Whitening seed, trellis tail byte and reported byte counts.
  localparam logic [8:0] WHITEN_SEED   = 9'h1FF;
  localparam logic [7:0] TRELLIS_TAIL  = 8'h0B;
  localparam logic [2:0] COUNT_WHITEN  = 3'd1;
  localparam logic [2:0] COUNT_FEC     = 3'd4;

  // Encoder branch outputs for each 4-bit window, entry 0 in the low bits.
  localparam logic [31:0] BRANCH_LUT = {
    2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3,
    2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0
  };

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_frame;
  } frame_byte_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        frame_end;
  } coded_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pn9fie_in_if  req_if ();
  pn9fie_out_if res_if ();

  pn9_fec_interleave_encoder uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bytes waiting to be driven and coded results still owed by the block.
  frame_byte_t   frame_bytes [$];
  coded_result_t coded_results_due [$];

  // Predicted encoder state and mode.
  coding_mode_e mode_shadow  = MODE_WHITEN;
  logic [8:0]   pn9_shadow   = WHITEN_SEED;
  logic [2:0]   coder_shadow = 3'd0;
  logic [15:0]  held_half    = 16'd0;
  logic         half_waiting = 1'b0;

  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;
  int unsigned src_gap     = 0;
  int unsigned src_calm    = 0;
  int unsigned sink_hold   = 0;
  int unsigned sink_calm   = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Two nibble steps of the PN9 sequence.
  function automatic logic [8:0] pn9_next(input logic [8:0] r);
    logic [8:0] x;
    for (int n = 0; n < 2; n++) begin
      x = ((r << 5) ^ r) & 9'h1E0;
      r = (r >> 4) | x;
    end
    return r;
  endfunction

  // Rate-1/2 coding of one byte behind three bits of memory.
  function automatic logic [15:0] trellis_code(input logic [2:0] mem, input logic [7:0] b);
    logic [10:0] sr;
    logic [15:0] acc;
    sr  = {mem, b};
    acc = 16'd0;
    for (int n = 0; n < 8; n++) begin
      acc = {acc[13:0], BRANCH_LUT[{sr[10:7], 1'b0} +: 2]};
      sr  = sr << 1;
    end
    return acc;
  endfunction

  // Spread the four coded bytes of a group across one word, two bits at a time.
  function automatic logic [31:0] interleave_group(input logic [15:0] first,
                                                   input logic [15:0] second);
    logic [7:0]  grp [4];
    logic [7:0]  s;
    logic [31:0] w;
    grp[0] = first[15:8];
    grp[1] = first[7:0];
    grp[2] = second[15:8];
    grp[3] = second[7:0];
    w = 32'd0;
    for (int j = 0; j < 16; j++) begin
      s = grp[3 - (j % 4)];
      w = {w[29:0], s[(j / 4) * 2 +: 2]};
    end
    return w;
  endfunction

  // Pause length: mostly none or short, now and then long.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Code one byte and pair it with the held half; a full pair yields a word.
  task automatic code_into_group(input logic [7:0] b, output logic done,
                                 output logic [31:0] w);
    logic [15:0] pair;
    pair         = trellis_code(coder_shadow, b);
    coder_shadow = b[2:0];
    w            = 32'd0;
    if (half_waiting) begin
      w            = interleave_group(held_half, pair);
      half_waiting = 1'b0;
      done         = 1'b1;
    end else begin
      held_half    = pair;
      half_waiting = 1'b1;
      done         = 1'b0;
    end
  endtask

  task automatic owe_result(input logic [31:0] w, input logic [2:0] cnt, input logic fe);
    coded_result_t r;
    r.word      = w;
    r.count     = cnt;
    r.frame_end = fe;
    coded_results_due.push_back(r);
  endtask

  // Work out the results of one accepted frame byte.
  task automatic encode_byte(input logic [7:0] raw, input logic last);
    logic [7:0]  wb;
    logic [31:0] w;
    logic        done;
    wb         = raw ^ pn9_shadow[7:0];
    pn9_shadow = pn9_next(pn9_shadow);
    if (mode_shadow == MODE_WHITEN) begin
      owe_result({24'd0, wb}, COUNT_WHITEN, last);
    end else begin
      code_into_group(wb, done, w);
      if (done) owe_result(w, COUNT_FEC, 1'b0);
      // Terminators pad the frame to an even number of coded bytes.
      if (last) begin
        if (!half_waiting) code_into_group(TRELLIS_TAIL, done, w);
        code_into_group(TRELLIS_TAIL, done, w);
        owe_result(w, COUNT_FEC, 1'b1);
      end
    end
    if (last) begin
      pn9_shadow   = WHITEN_SEED;
      coder_shadow = 3'd0;
      half_waiting = 1'b0;
    end
  endtask

  // Driver: present queued bytes with random gaps between requests.
  always @(posedge clk_i) begin
    frame_byte_t nxt;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        if (src_calm > 0) begin
          src_calm--;
          src_gap = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          src_calm = $urandom_range(20, 60);
          src_gap  = 0;
        end else begin
          src_gap = pick_pause();
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          nxt = frame_bytes.pop_front();
          req_if.valid         <= 1'b1;
          req_if.data_byte     <= nxt.data_byte;
          req_if.last_of_frame <= nxt.last_of_frame;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on accepted requests, check accepted results, drive the
  // sink's ready and watch for a stalled run.
  always @(posedge clk_i) begin
    coded_result_t due;
    logic          req_fire;
    logic          res_fire;
    if (rst_ni) begin
      req_fire = req_if.valid && req_if.ready;
      res_fire = res_if.valid && res_if.ready;
      if (req_fire) encode_byte(req_if.data_byte, req_if.last_of_frame);

      if (res_fire) begin
        if (coded_results_due.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: unexpected result word %h count %0d frame_end %0b", $time,
                     res_if.coded_word, res_if.byte_count, res_if.frame_end);
          fail_count++;
        end else begin
          due = coded_results_due.pop_front();
          if (res_if.coded_word !== due.word || res_if.byte_count !== due.count ||
              res_if.frame_end !== due.frame_end) begin
            if (fail_count < REPORT_LIMIT) begin
              if (res_if.coded_word !== due.word)
                $display("%0t: coded_word expected %h, got %h", $time, due.word,
                         res_if.coded_word);
              if (res_if.byte_count !== due.count)
                $display("%0t: byte_count expected %0d, got %0d", $time, due.count,
                         res_if.byte_count);
              if (res_if.frame_end !== due.frame_end)
                $display("%0t: frame_end expected %0b, got %0b", $time, due.frame_end,
                         res_if.frame_end);
            end
            fail_count++;
          end
        end
      end

      // Receiver stalls: short holds, a few long ones, and calm stretches.
      if (sink_hold > 0) begin
        sink_hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 49) == 0) sink_calm = $urandom_range(20, 60);
        else sink_hold = pick_pause();
      end

      if (req_fire || res_fire) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("pn9_fec_interleave_encoder: mismatch");
        $finish;
      end
    end
  end

  task automatic send(input logic [7:0] b, input logic last);
    frame_byte_t fb;
    fb.data_byte     = b;
    fb.last_of_frame = last;
    frame_bytes.push_back(fb);
  endtask

  // Wait until every byte is taken and every result has come, then let the
  // block finish any byte that owes no result.
  task automatic settle();
    do @(negedge clk_i);
    while (frame_bytes.size() != 0 || req_if.valid || coded_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the mode register with noise in the unused bits, then read it back.
  task automatic write_mode(input coding_mode_e mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FEC_MODE_ADDR;
    pwdata  <= ($urandom & 32'hFFFF_FFFE) | 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    mode_shadow = mode;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(mode)) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t: fec_mode readback expected %h, got %h", $time, 32'(mode), prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stimulus.
  initial begin
    int unsigned budget;
    int unsigned flen;
    logic [7:0]  b;

    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.data_byte     = 8'd0;
    req_if.last_of_frame = 1'b0;
    res_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = 3'd0;
    pwdata               = 32'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Whitening from the reset mode: extremes in a three-byte frame, a one-byte
    // frame, then an open frame that continues in FEC mode.
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'hA5, 1'b1);
    send(8'h5A, 1'b1);
    send(8'h3C, 1'b0);
    settle();
    write_mode(MODE_FEC);

    // Even count (two terminators), odd counts (one terminator), open frame.
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send(8'h81, 1'b1);
    send(8'h12, 1'b0);
    send(8'h34, 1'b0);
    send(8'h56, 1'b1);
    send(8'h77, 1'b0);
    settle();

    // Whitening bytes in the middle of a frame leave the held half alone.
    write_mode(MODE_WHITEN);
    send(8'hC3, 1'b0);
    send(8'h99, 1'b0);
    settle();
    write_mode(MODE_FEC);
    send(8'hEE, 1'b1);
    send(8'h10, 1'b0);
    settle();

    // A whitening frame end still clears the held half.
    write_mode(MODE_WHITEN);
    send(8'h20, 1'b1);
    settle();
    write_mode(MODE_FEC);
    send(8'h30, 1'b1);

    // Random frames in phases; a phase may stop in the middle of a frame.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_mode((p % 3 == 1) ? MODE_WHITEN : MODE_FEC);
      budget = 66;
      while (budget > 0) begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
        for (int k = 0; k < flen && budget > 0; k++) begin
          if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else b = 8'($urandom);
          send(b, k == flen - 1);
          budget--;
        end
      end
    end

    do @(negedge clk_i);
    while (frame_bytes.size() != 0 || req_if.valid || coded_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (coded_results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, coded_results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("pn9_fec_interleave_encoder: match");
    end else begin
      $display("pn9_fec_interleave_encoder: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pn9fie_pkg.sv
rtl/pn9fie_in_if.sv
rtl/pn9fie_out_if.sv
rtl/pn9fie_coder.sv
rtl/pn9fie_res_fifo.sv
rtl/pn9_fec_interleave_encoder.sv
rtl/pn9fie_checker.sv
tb/pn9_fec_interleave_encoder_tb.sv
